FILE: rtl/snh_pkg.sv
// ----------------------------------------------------------------------------
// snh_pkg
// Shared types, widths and pipeline stage numbers of the stable Neo-Hookean
// gradient block.
// ----------------------------------------------------------------------------
package snh_pkg;

    localparam int N_ENT     = 9;
    localparam int MUL_LAT   = 4;
    localparam int DIV_STEPS = 79;

    localparam int ST_PROD   = MUL_LAT;
    localparam int ST_COF    = ST_PROD + 1;
    localparam int ST_DIVIN  = ST_COF + 1;
    localparam int ST_J      = ST_COF + MUL_LAT;
    localparam int ST_JSUM   = ST_J + 1;
    localparam int ST_DIVOUT = ST_DIVIN + DIV_STEPS;
    localparam int ST_M      = ST_DIVOUT + MUL_LAT;
    localparam int ST_K      = ST_M + 1;
    localparam int ST_A      = ST_M + MUL_LAT;
    localparam int ST_B      = ST_K + MUL_LAT;
    localparam int ST_OUT    = ST_B + 1;

    typedef logic [3:0] ent_idx_t;

    localparam ent_idx_t COF_IDX [N_ENT][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd1, 4'd5, 4'd2, 4'd4}, '{4'd2, 4'd3, 4'd0, 4'd5}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic signed [31:0] defgrad_0;
        logic signed [31:0] defgrad_1;
        logic signed [31:0] defgrad_2;
        logic signed [31:0] defgrad_3;
        logic signed [31:0] defgrad_4;
        logic signed [31:0] defgrad_5;
        logic signed [31:0] defgrad_6;
        logic signed [31:0] defgrad_7;
        logic signed [31:0] defgrad_8;
        logic [31:0]        youngs_modulus;
        logic [14:0]        poisson_ratio;
        logic               last_element;
    } tet_t;

    typedef struct packed {
        logic signed [63:0] grad_0;
        logic signed [63:0] grad_1;
        logic signed [63:0] grad_2;
        logic signed [63:0] grad_3;
        logic signed [63:0] grad_4;
        logic signed [63:0] grad_5;
        logic signed [63:0] grad_6;
        logic signed [63:0] grad_7;
        logic signed [63:0] grad_8;
        logic               last_out;
    } grad_t;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

endpackage

FILE: rtl/snh_stream_if.sv
// ----------------------------------------------------------------------------
// snh_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface snh_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/stable_neohookean_gradient.sv
// ----------------------------------------------------------------------------
// stable_neohookean_gradient
// Stable Neo-Hookean energy gradient of one tetrahedron per transfer.
//
// Channel tet takes nine deformation-gradient entries (signed Q8.24), the
// Young's modulus in pascals and the Poisson ratio (Q0.16). Channel res
// returns the nine gradient entries (signed Q40.24, saturated) and a copy
// of the last-element flag.
// A new element can be taken every cycle while res is not stalled. The
// pipeline holds the 79 one-bit stages of the three parallel dividers
// and the 4-stage split multipliers around them. Reset clears all valid
// bits; the pipeline then holds no item.
// When res is stalled, every stage holds and tet.ready drops; it rises as
// soon as the output register is empty or being transferred, so nothing
// is lost or repeated.
// ----------------------------------------------------------------------------
module stable_neohookean_gradient (
    input logic         clk,
    input logic         rst_n,
    snh_stream_if.sink   tet,
    snh_stream_if.source res
);
    import snh_pkg::*;

    typedef struct packed {
        logic [31:0] e;
        logic [14:0] p;
    } ep_t;

    typedef struct packed {
        logic [46:0] q;
        logic [54:0] x;
    } c1_t;

    logic              adv;
    logic [ST_OUT:0]   v_reg;
    tet_t              in_reg;
    logic signed [31:0] s0 [N_ENT];

    logic signed [31:0] s_pipe_reg   [1:ST_DIVOUT][N_ENT];
    ep_t                ep_pipe_reg  [1:ST_COF];
    logic               last_pipe_reg[1:ST_B];
    logic signed [40:0] cof_pipe_reg [ST_COF:ST_K][N_ENT];
    logic signed [48:0] j_pipe_reg   [ST_JSUM:ST_DIVOUT];
    c1_t                c1_pipe_reg  [ST_DIVOUT+1:ST_M];

    logic signed [63:0] sq_out [N_ENT];
    logic signed [63:0] pa_out [N_ENT];
    logic signed [63:0] pb_out [N_ENT];
    logic signed [63:0] jt_out [N_ENT];
    logic signed [63:0] m_out  [N_ENT];
    logic signed [63:0] a_out  [N_ENT];
    logic signed [63:0] b_out  [N_ENT];
    logic signed [63:0] d1j_out;

    logic [39:0]        grp_reg [3];
    logic [42:0]        den_reg;
    logic [46:0]        t_reg;
    logic [32:0]        dd_reg;
    logic [16:0]        c1den_reg;
    logic [31:0]        e6_reg;
    logic [16:0]        nu_plus;
    logic [16:0]        nu_minus;

    logic [78:0]        c1_quo;
    logic [78:0]        qr_quo;
    logic [78:0]        d1_quo;
    logic [49:0]        jm1;
    logic [33:0]        r32;
    logic [54:0]        c1x_next;
    logic signed [63:0] k_reg;
    logic signed [63:0] a94_reg [N_ENT];
    grad_t              out_reg;
    grad_t              out_next;

    assign adv       = !v_reg[ST_OUT] || res.ready;
    assign tet.ready = adv;
    assign res.valid = v_reg[ST_OUT];
    assign res.data  = out_reg;

    assign s0[0] = in_reg.defgrad_0;
    assign s0[1] = in_reg.defgrad_1;
    assign s0[2] = in_reg.defgrad_2;
    assign s0[3] = in_reg.defgrad_3;
    assign s0[4] = in_reg.defgrad_4;
    assign s0[5] = in_reg.defgrad_5;
    assign s0[6] = in_reg.defgrad_6;
    assign s0[7] = in_reg.defgrad_7;
    assign s0[8] = in_reg.defgrad_8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[ST_OUT-1:0], tet.valid};
        end
    end

    // squares and cofactor products
    for (genvar i = 0; i < N_ENT; i++)
    begin : g_front
        snh_mulq #(.SH(24)) u_sq (
            .clk (clk), .en (adv),
            .a   ({{32{s0[i][31]}}, s0[i]}),
            .b   ({{32{s0[i][31]}}, s0[i]}),
            .y   (sq_out[i])
        );
        snh_mulq #(.SH(24)) u_pa (
            .clk (clk), .en (adv),
            .a   ({{32{s0[COF_IDX[i][0]][31]}}, s0[COF_IDX[i][0]]}),
            .b   ({{32{s0[COF_IDX[i][1]][31]}}, s0[COF_IDX[i][1]]}),
            .y   (pa_out[i])
        );
        snh_mulq #(.SH(24)) u_pb (
            .clk (clk), .en (adv),
            .a   ({{32{s0[COF_IDX[i][2]][31]}}, s0[COF_IDX[i][2]]}),
            .b   ({{32{s0[COF_IDX[i][3]][31]}}, s0[COF_IDX[i][3]]}),
            .y   (pb_out[i])
        );
        snh_mulq #(.SH(24)) u_jt (
            .clk (clk), .en (adv),
            .a   ({{32{s_pipe_reg[ST_COF][i][31]}}, s_pipe_reg[ST_COF][i]}),
            .b   ({{23{cof_pipe_reg[ST_COF][i][40]}}, cof_pipe_reg[ST_COF][i]}),
            .y   (jt_out[i])
        );
        snh_mulq #(.SH(32)) u_m (
            .clk (clk), .en (adv),
            .a   ({{32{s_pipe_reg[ST_DIVOUT][i][31]}}, s_pipe_reg[ST_DIVOUT][i]}),
            .b   ({30'd0, r32}),
            .y   (m_out[i])
        );
        snh_mulq #(.SH(16)) u_a (
            .clk (clk), .en (adv),
            .a   ({17'd0, c1_pipe_reg[ST_M].q}),
            .b   (m_out[i]),
            .y   (a_out[i])
        );
        snh_mulq #(.SH(24)) u_b (
            .clk (clk), .en (adv),
            .a   ({{23{cof_pipe_reg[ST_K][i][40]}}, cof_pipe_reg[ST_K][i]}),
            .b   (k_reg),
            .y   (b_out[i])
        );
    end

    assign nu_plus  = 17'h10000 + {2'd0, ep_pipe_reg[ST_COF].p};
    assign nu_minus = 17'h10000 - {1'b0, ep_pipe_reg[ST_COF].p, 1'b0};

    snh_div #(.NW(DIV_STEPS), .DW(17)) u_div_c1 (
        .clk (clk), .en (adv),
        .num ({16'd0, e6_reg, 31'd0}),
        .den (c1den_reg),
        .quo (c1_quo)
    );

    snh_div #(.NW(DIV_STEPS), .DW(43)) u_div_r (
        .clk (clk), .en (adv),
        .num ({22'd0, 1'b1, 56'd0}),
        .den (den_reg),
        .quo (qr_quo)
    );

    snh_div #(.NW(DIV_STEPS), .DW(33)) u_div_d1 (
        .clk (clk), .en (adv),
        .num ({t_reg, 32'd0}),
        .den (dd_reg),
        .quo (d1_quo)
    );

    assign jm1      = {j_pipe_reg[ST_DIVOUT][48], j_pipe_reg[ST_DIVOUT]}
                      - {25'd0, 1'b1, 24'd0};
    assign r32      = {2'b01, 32'd0} - {1'b0, qr_quo[32:0]};
    assign c1x_next = {1'b0, c1_quo[46:0], 7'd0} + {2'd0, c1_quo[46:0], 6'd0};

    snh_mulq #(.SH(16)) u_d1j (
        .clk (clk), .en (adv),
        .a   ({2'd0, d1_quo[61:0]}),
        .b   ({{14{jm1[49]}}, jm1}),
        .y   (d1j_out)
    );

    always_comb
    begin
        out_next          = '0;
        out_next.grad_0   = sat_add64(a94_reg[0], b_out[0]);
        out_next.grad_1   = sat_add64(a94_reg[1], b_out[1]);
        out_next.grad_2   = sat_add64(a94_reg[2], b_out[2]);
        out_next.grad_3   = sat_add64(a94_reg[3], b_out[3]);
        out_next.grad_4   = sat_add64(a94_reg[4], b_out[4]);
        out_next.grad_5   = sat_add64(a94_reg[5], b_out[5]);
        out_next.grad_6   = sat_add64(a94_reg[6], b_out[6]);
        out_next.grad_7   = sat_add64(a94_reg[7], b_out[7]);
        out_next.grad_8   = sat_add64(a94_reg[8], b_out[8]);
        out_next.last_out = last_pipe_reg[ST_B];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg <= tet.data;

            for (int i = 0; i < N_ENT; i++)
            begin
                s_pipe_reg[1][i] <= s0[i];
            end
            for (int k = 2; k <= ST_DIVOUT; k++)
            begin
                s_pipe_reg[k] <= s_pipe_reg[k-1];
            end

            ep_pipe_reg[1] <= '{e: in_reg.youngs_modulus, p: in_reg.poisson_ratio};
            for (int k = 2; k <= ST_COF; k++)
            begin
                ep_pipe_reg[k] <= ep_pipe_reg[k-1];
            end

            last_pipe_reg[1] <= in_reg.last_element;
            for (int k = 2; k <= ST_B; k++)
            begin
                last_pipe_reg[k] <= last_pipe_reg[k-1];
            end

            for (int i = 0; i < N_ENT; i++)
            begin
                cof_pipe_reg[ST_COF][i] <= 41'(pa_out[i] - pb_out[i]);
            end
            for (int k = ST_COF + 1; k <= ST_K; k++)
            begin
                cof_pipe_reg[k] <= cof_pipe_reg[k-1];
            end

            for (int g = 0; g < 3; g++)
            begin
                grp_reg[g] <= 40'(sq_out[3*g]) + 40'(sq_out[3*g+1]) + 40'(sq_out[3*g+2]);
            end

            den_reg   <= {18'd0, 1'b1, 24'd0} + {3'd0, grp_reg[0]} + {3'd0, grp_reg[1]}
                         + {3'd0, grp_reg[2]};
            t_reg     <= {15'd0, ep_pipe_reg[ST_COF].e} * {32'd0, ep_pipe_reg[ST_COF].p};
            dd_reg    <= {16'd0, nu_plus} * {16'd0, nu_minus};
            c1den_reg <= nu_plus;
            e6_reg    <= ep_pipe_reg[ST_COF].e;

            j_pipe_reg[ST_JSUM] <= 49'(jt_out[0]) + 49'(jt_out[1]) + 49'(jt_out[2]);
            for (int k = ST_JSUM + 1; k <= ST_DIVOUT; k++)
            begin
                j_pipe_reg[k] <= j_pipe_reg[k-1];
            end

            c1_pipe_reg[ST_DIVOUT+1] <= '{q: c1_quo[46:0], x: c1x_next};
            for (int k = ST_DIVOUT + 2; k <= ST_M; k++)
            begin
                c1_pipe_reg[k] <= c1_pipe_reg[k-1];
            end

            k_reg <= sat_add64(d1j_out, -$signed({9'd0, c1_pipe_reg[ST_M].x}));

            for (int i = 0; i < N_ENT; i++)
            begin
                a94_reg[i] <= a_out[i];
            end

            out_reg <= out_next;
        end
    end

endmodule

FILE: rtl/snh_mulq.sv
// ----------------------------------------------------------------------------
// snh_mulq
// Four-stage signed multiply, right shift toward zero and 64-bit saturation,
// built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module snh_mulq #(
    parameter int SH = 24
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] y
);

    logic [63:0]        ua_reg;
    logic [63:0]        ub_reg;
    logic               neg1_reg;
    logic               neg2_reg;
    logic               neg3_reg;
    logic [63:0]        p00_reg;
    logic [63:0]        p01_reg;
    logic [63:0]        p10_reg;
    logic [63:0]        p11_reg;
    logic [127:0]       prod_reg;
    logic signed [63:0] y_reg;
    logic [127:0]       shifted;
    logic [63:0]        lim;
    logic [63:0]        mag_sat;

    always_comb
    begin
        shifted = prod_reg >> SH;
        lim     = neg3_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        mag_sat = (shifted[127:64] != 64'd0 || shifted[63:0] > lim) ? lim : shifted[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg   <= a[63] ? (~a) + 64'd1 : a;
            ub_reg   <= b[63] ? (~b) + 64'd1 : b;
            neg1_reg <= a[63] ^ b[63];
            p00_reg  <= {32'd0, ua_reg[31:0]} * {32'd0, ub_reg[31:0]};
            p01_reg  <= {32'd0, ua_reg[31:0]} * {32'd0, ub_reg[63:32]};
            p10_reg  <= {32'd0, ua_reg[63:32]} * {32'd0, ub_reg[31:0]};
            p11_reg  <= {32'd0, ua_reg[63:32]} * {32'd0, ub_reg[63:32]};
            neg2_reg <= neg1_reg;
            prod_reg <= {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                        + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
            neg3_reg <= neg2_reg;
            y_reg    <= neg3_reg ? (~mag_sat) + 64'd1 : mag_sat;
        end
    end

    assign y = y_reg;

endmodule

FILE: rtl/snh_div.sv
// ----------------------------------------------------------------------------
// snh_div
// Pipelined restoring divider: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module snh_div #(
    parameter int NW = 79,
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    logic [DW-1:0] rem_reg [NW];
    logic [DW-1:0] den_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] quo_reg [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_step
        logic [DW-1:0] r_in;
        logic [DW-1:0] d_in;
        logic [NW-1:0] n_in;
        logic [NW-1:0] q_in;
        logic [DW:0]   cand;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign r_in = '0;
            assign d_in = den;
            assign n_in = num;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign r_in = rem_reg[k-1];
            assign d_in = den_reg[k-1];
            assign n_in = num_reg[k-1];
            assign q_in = quo_reg[k-1];
        end

        assign cand = {r_in, n_in[NW-1]};
        assign ge   = cand >= {1'b0, d_in};
        assign diff = cand - {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DW-1:0] : cand[DW-1:0];
                den_reg[k] <= d_in;
                num_reg[k] <= {n_in[NW-2:0], 1'b0};
                quo_reg[k] <= {q_in[NW-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[NW-1];

endmodule

FILE: rtl/snh_checker.sv
// ----------------------------------------------------------------------------
// snh_checker
// Port-level checks of the gradient block's handshake and flow control.
// ----------------------------------------------------------------------------
module snh_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               tet_valid,
    input logic               tet_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic               res_last,
    input logic signed [63:0] res_grad0
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_last) && $stable(res_grad0))
        else $error("res transfer dropped or changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> tet_ready)
        else $error("tet stalled with an empty output register");

    a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |-> tet_ready)
        else $error("tet stalled while the result is transferred");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("res valid after reset");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !tet_ready)
        else $error("tet ready while res is stalled");

endmodule

bind stable_neohookean_gradient snh_checker u_snh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tet_valid (tet.valid),
    .tet_ready (tet.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_last  (res.data.last_out),
    .res_grad0 (res.data.grad_0)
);
